// ===== rtl/ffa_pkg.sv =====
// Shared constants and types for the first-fit free-list allocator.
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int PAGE_BYTES    = 4096;
    localparam int HDR_BYTES     = 16;
    localparam int PAGE_WORDS    = PAGE_BYTES / 8;
    localparam int PAGE_WORDS_LG = $clog2(PAGE_WORDS);
    localparam int USABLE_BYTES  = PAGE_BYTES - HDR_BYTES;

    localparam int SIZE_W  = 12;  // size field of a header
    localparam int OPD_W   = 13;  // operand width of the shared subtractor
    localparam int REQ_W   = 12;
    localparam int ADDR_W  = 18;
    localparam int PAGES_W = 7;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    // Write enables for the two halves of a header word.
    typedef struct packed {
        logic size;
        logic link;
    } t_wr_en;

endpackage

// ===== rtl/ffa_hdr_store.sv =====
// Header store: size and link halves, one write and one registered read per cycle.
`timescale 1ns / 1ps

module ffa_hdr_store #(
    parameter int DEPTH  = 32768,
    parameter int IDX_W  = 15,
    parameter int LINK_W = 16
) (
    input  logic                         i_clk,
    input  ffa_pkg::t_wr_en              i_wr_en,
    input  logic [IDX_W-1:0]             i_wr_idx,
    input  logic [ffa_pkg::SIZE_W-1:0]   i_wr_size,
    input  logic [LINK_W-1:0]            i_wr_link,
    input  logic [IDX_W-1:0]             i_rd_idx,
    output logic [ffa_pkg::SIZE_W-1:0]   o_rd_size,
    output logic [LINK_W-1:0]            o_rd_link
);

    logic [ffa_pkg::SIZE_W-1:0] r_size_mem [DEPTH];
    logic [LINK_W-1:0]          r_link_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en.size) begin
            r_size_mem[i_wr_idx] <= i_wr_size;
        end
        o_rd_size <= r_size_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en.link) begin
            r_link_mem[i_wr_idx] <= i_wr_link;
        end
        o_rd_link <= r_link_mem[i_rd_idx];
    end

endmodule

// ===== rtl/ffa_alu.sv =====
// Shared subtract/compare unit: fit test, remainder and split size.
`timescale 1ns / 1ps

module ffa_alu (
    input  logic [ffa_pkg::OPD_W-1:0] i_a,
    input  logic [ffa_pkg::OPD_W-1:0] i_b,
    output logic [ffa_pkg::OPD_W-1:0] o_diff,
    output logic                      o_ge,
    output logic                      o_gt
);

    logic [ffa_pkg::OPD_W:0] diff_ext;

    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = diff_ext[ffa_pkg::OPD_W-1:0];
    assign o_ge     = ~diff_ext[ffa_pkg::OPD_W];
    assign o_gt     = o_ge && (o_diff != '0);

endmodule

// ===== rtl/first_fit_free_list_allocator_unit.sv =====
// Top level: first-fit free-list heap allocator with its sequencer.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  request  | in        | start, busy        | i_mode, i_request_bytes, i_block_address
//  result   | out       | o_done (1 cycle)   | o_object_address, o_status, o_pages_in_use
//
//  A request transfers when start is high and busy is low; busy stays high through the
//  o_done cycle. An allocation walks the list one header per cycle (single read port),
//  then unlinks, takes and splits the block; a new-page step comes first if none fits.
//  A free links the block in, an oversized request skips all steps; then back to idle.
//  Reset (synchronous, active low) empties the free list and zeroes the page count;
//  header store left as it is, no clearing pass. Receiver cannot stall.
`timescale 1ns / 1ps

module first_fit_free_list_allocator_unit #(
    parameter int HEAP_PAGES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [ffa_pkg::REQ_W-1:0]     i_request_bytes,
    input  logic [ffa_pkg::ADDR_W-1:0]    i_block_address,
    output logic                          o_done,
    output logic [ffa_pkg::ADDR_W-1:0]    o_object_address,
    output logic                          o_status,
    output logic [ffa_pkg::PAGES_W-1:0]   o_pages_in_use
);

    localparam int STORE_WORDS = HEAP_PAGES * ffa_pkg::PAGE_WORDS;
    localparam int IW          = $clog2(STORE_WORDS);      // header index
    localparam int LW          = $clog2(STORE_WORDS + 1);  // link, holds the null marker
    localparam int CW          = $clog2(STORE_WORDS + 1);  // walk step count
    localparam int PW          = $clog2(HEAP_PAGES + 1);
    localparam int OBJ_W       = IW + 4;
    localparam int FIDX_W      = ffa_pkg::ADDR_W - 3;

    localparam logic [LW-1:0] NIL = LW'(STORE_WORDS);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_WALK   = 8'b0000_0010,
        S_NEWPG  = 8'b0000_0100,
        S_UNLINK = 8'b0000_1000,
        S_TAKE   = 8'b0001_0000,
        S_SPLIT  = 8'b0010_0000,
        S_FREE   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    // control state
    t_state  r_state, n_state;
    logic [LW-1:0] r_head, n_head;
    logic [PW-1:0] r_pages, n_pages;

    // working registers
    logic [ffa_pkg::OPD_W-1:0]  r_sz, n_sz;
    logic [IW-1:0]              r_cur, n_cur;
    logic [IW-1:0]              r_prev, n_prev;
    logic                       r_prev_vld, n_prev_vld;
    logic [CW-1:0]              r_steps, n_steps;
    logic [ffa_pkg::SIZE_W-1:0] r_cur_size, n_cur_size;
    logic [LW-1:0]              r_cur_next, n_cur_next;
    logic [ffa_pkg::SIZE_W-1:0] r_rem, n_rem;
    logic                       r_free_ok, n_free_ok;
    logic [IW-1:0]              r_free_idx, n_free_idx;
    logic [ffa_pkg::ADDR_W-1:0] r_obj, n_obj;
    logic                       r_status, n_status;

    // header store port
    ffa_pkg::t_wr_en            wr_en;
    logic [IW-1:0]              wr_idx;
    logic [ffa_pkg::SIZE_W-1:0] wr_size;
    logic [LW-1:0]              wr_link;
    logic [IW-1:0]              rd_idx;
    logic [ffa_pkg::SIZE_W-1:0] rd_size;
    logic [LW-1:0]              rd_link;

    // shared subtractor
    logic [ffa_pkg::OPD_W-1:0]  alu_a, alu_b, alu_diff;
    logic                       alu_ge, alu_gt;

    // request decode
    logic [ffa_pkg::OPD_W-1:0]  req_round, req_sz;
    logic [ffa_pkg::ADDR_W-1:0] free_off;
    logic [FIDX_W-1:0]          free_idx;
    logic                       free_ok;
    logic [CW-1:0]              steps_inc;
    logic [IW:0]                split_idx;
    logic [OBJ_W-1:0]           obj_full;

    ffa_hdr_store #(
        .DEPTH  (STORE_WORDS),
        .IDX_W  (IW),
        .LINK_W (LW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_size (wr_size),
        .i_wr_link (wr_link),
        .i_rd_idx  (rd_idx),
        .o_rd_size (rd_size),
        .o_rd_link (rd_link)
    );

    ffa_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_diff),
        .o_ge   (alu_ge),
        .o_gt   (alu_gt)
    );

    // size rounded up to a multiple of 8, at least 8
    assign req_round = ({1'b0, i_request_bytes} + ffa_pkg::OPD_W'(7)) & ~ffa_pkg::OPD_W'(7);
    assign req_sz    = (req_round == '0) ? ffa_pkg::OPD_W'(8) : req_round;

    // free address: aligned, past the first header, header inside the heap
    assign free_off = i_block_address - ffa_pkg::ADDR_W'(ffa_pkg::HDR_BYTES);
    assign free_idx = free_off[ffa_pkg::ADDR_W-1:3];
    assign free_ok  = (i_block_address[2:0] == 3'b000)
                   && (i_block_address >= ffa_pkg::ADDR_W'(ffa_pkg::HDR_BYTES))
                   && (32'(free_idx) < STORE_WORDS);

    assign steps_inc = r_steps + CW'(1);
    // remainder header sits just past the granted object
    assign split_idx = (IW+1)'(r_cur) + (IW+1)'(2) + (IW+1)'(r_sz >> 3);
    assign obj_full  = OBJ_W'({r_cur, 3'b000}) + OBJ_W'(ffa_pkg::HDR_BYTES);

    // operand selection for the shared subtractor
    always_comb begin
        alu_a = ffa_pkg::OPD_W'(rd_size);
        alu_b = r_sz;
        unique case (r_state)
            S_UNLINK: begin
                alu_a = ffa_pkg::OPD_W'(r_cur_size);
                alu_b = r_sz;
            end
            S_SPLIT: begin
                alu_a = ffa_pkg::OPD_W'(r_rem);
                alu_b = ffa_pkg::OPD_W'(ffa_pkg::HDR_BYTES);
            end
            default: begin
                alu_a = ffa_pkg::OPD_W'(rd_size);
                alu_b = r_sz;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_pages    = r_pages;
        n_sz       = r_sz;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_prev_vld = r_prev_vld;
        n_steps    = r_steps;
        n_cur_size = r_cur_size;
        n_cur_next = r_cur_next;
        n_rem      = r_rem;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_obj      = r_obj;
        n_status   = r_status;
        wr_en      = '0;
        wr_idx     = r_cur;
        wr_size    = ffa_pkg::SIZE_W'(r_sz);
        wr_link    = NIL;
        rd_idx     = r_cur;

        unique case (r_state)
            S_IDLE: begin
                rd_idx = IW'(r_head);
                if (start) begin
                    n_obj    = '0;
                    n_status = ffa_pkg::STATUS_OK;
                    if (i_mode == ffa_pkg::MODE_FREE) begin
                        n_free_ok  = free_ok;
                        n_free_idx = IW'(free_idx);
                        n_state    = S_FREE;
                    end else if (32'(req_sz) > ffa_pkg::USABLE_BYTES) begin
                        n_status = ffa_pkg::STATUS_OOM;
                        n_state  = S_DONE;
                    end else begin
                        n_sz       = req_sz;
                        n_cur      = IW'(r_head);
                        n_prev_vld = 1'b0;
                        n_steps    = '0;
                        n_state    = (32'(r_head) >= STORE_WORDS) ? S_NEWPG : S_WALK;
                    end
                end
            end

            S_WALK: begin
                // header of r_cur is on the read port this cycle
                if (alu_ge) begin
                    n_cur_size = rd_size;
                    n_cur_next = rd_link;
                    n_state    = S_UNLINK;
                end else if ((32'(rd_link) >= STORE_WORDS)
                          || (32'(steps_inc) >= STORE_WORDS)) begin
                    n_state = S_NEWPG;
                end else begin
                    n_prev     = r_cur;
                    n_prev_vld = 1'b1;
                    n_cur      = IW'(rd_link);
                    n_steps    = steps_inc;
                    rd_idx     = IW'(rd_link);
                end
            end

            S_NEWPG: begin
                // a fresh page pushed and popped at once: head is unchanged
                if (32'(r_pages) >= HEAP_PAGES) begin
                    n_status = ffa_pkg::STATUS_OOM;
                    n_state  = S_DONE;
                end else begin
                    n_cur      = IW'({r_pages, {ffa_pkg::PAGE_WORDS_LG{1'b0}}});
                    n_cur_size = ffa_pkg::SIZE_W'(ffa_pkg::USABLE_BYTES);
                    n_cur_next = r_head;
                    n_prev_vld = 1'b0;
                    n_pages    = r_pages + PW'(1);
                    n_state    = S_UNLINK;
                end
            end

            S_UNLINK: begin
                if (r_prev_vld) begin
                    wr_en.link = 1'b1;
                    wr_idx     = r_prev;
                    wr_link    = r_cur_next;
                end else begin
                    n_head = r_cur_next;
                end
                n_rem   = ffa_pkg::SIZE_W'(alu_diff);
                n_state = S_TAKE;
            end

            S_TAKE: begin
                wr_en.size = 1'b1;
                wr_en.link = 1'b1;
                wr_idx     = r_cur;
                wr_size    = ffa_pkg::SIZE_W'(r_sz);
                wr_link    = NIL;
                n_state    = S_SPLIT;
            end

            S_SPLIT: begin
                if (alu_gt && (32'(split_idx) < STORE_WORDS)) begin
                    wr_en.size = 1'b1;
                    wr_en.link = 1'b1;
                    wr_idx     = IW'(split_idx);
                    wr_size    = ffa_pkg::SIZE_W'(alu_diff);
                    wr_link    = r_head;
                    n_head     = LW'(split_idx);
                end
                n_obj   = ffa_pkg::ADDR_W'(obj_full);
                n_state = S_DONE;
            end

            S_FREE: begin
                if (r_free_ok) begin
                    wr_en.link = 1'b1;
                    wr_idx     = r_free_idx;
                    wr_link    = r_head;
                    n_head     = LW'(r_free_idx);
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL;
            r_pages <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_pages <= n_pages;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sz       <= n_sz;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_prev_vld <= n_prev_vld;
        r_steps    <= n_steps;
        r_cur_size <= n_cur_size;
        r_cur_next <= n_cur_next;
        r_rem      <= n_rem;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_obj      <= n_obj;
        r_status   <= n_status;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = (r_state == S_DONE);
    assign o_object_address = r_obj;
    assign o_status         = r_status;
    assign o_pages_in_use   = ffa_pkg::PAGES_W'(r_pages);

endmodule

// ===== dv/first_fit_free_list_allocator_unit_tb.sv =====
// Testbench for the first-fit free-list allocator: directed and random requests against a predictor.
`timescale 1ns / 1ps

module first_fit_free_list_allocator_unit_tb;

    localparam int HEAP_PAGES  = 64;
    localparam int STORE_WORDS = HEAP_PAGES * ffa_pkg::PAGE_WORDS;
    localparam int NO_LINK     = STORE_WORDS;     // end-of-list marker, just past the store
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [ffa_pkg::ADDR_W-1:0]  obj_addr;
        logic                        status;
        logic [ffa_pkg::PAGES_W-1:0] pages;
    } t_heap_reply;

    // Clock, reset and block inputs: all known from time zero.
    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        start           = 1'b0;
    logic                        i_mode          = ffa_pkg::MODE_ALLOC;
    logic [ffa_pkg::REQ_W-1:0]   i_request_bytes = '0;
    logic [ffa_pkg::ADDR_W-1:0]  i_block_address = '0;
    logic                        busy;
    logic                        o_done;
    logic [ffa_pkg::ADDR_W-1:0]  o_object_address;
    logic                        o_status;
    logic [ffa_pkg::PAGES_W-1:0] o_pages_in_use;

    always #5 i_clk = ~i_clk;

    first_fit_free_list_allocator_unit #(
        .HEAP_PAGES(HEAP_PAGES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_request_bytes (i_request_bytes),
        .i_block_address (i_block_address),
        .o_done          (o_done),
        .o_object_address(o_object_address),
        .o_status        (o_status),
        .o_pages_in_use  (o_pages_in_use)
    );

    // ------------------------------------------------------------------
    // Heap predictor: one header per 8-byte word, a LIFO free list and
    // the page count. Entries never written read as zero, but the stimulus
    // never puts such an entry on the list.
    // ------------------------------------------------------------------
    bit [ffa_pkg::SIZE_W-1:0] blk_size [STORE_WORDS];
    int unsigned              blk_link [STORE_WORDS];
    int unsigned              list_head  = NO_LINK;
    int unsigned              pages_used = 0;

    t_heap_reply     pending_replies [$];   // expected results, oldest first

    // Objects handed out and not yet freed; frees in the random traffic only
    // come from here, so the list never holds a block twice.
    logic [ffa_pkg::ADDR_W-1:0] live_objects [$];
    bit                         obj_live [STORE_WORDS];

    logic [ffa_pkg::ADDR_W-1:0] first_obj;           // lowest object address of the heap
    logic [ffa_pkg::ADDR_W-1:0] page_obj;            // object that fills a whole page

    int mismatches = 0;

    function automatic t_heap_reply predict_heap(input logic mode,
                                                 input logic [ffa_pkg::REQ_W-1:0] req,
                                                 input logic [ffa_pkg::ADDR_W-1:0] addr);
        t_heap_reply reply;
        int unsigned want, cur, prev, steps, spare, obj, split;
        reply.obj_addr = '0;
        reply.status   = ffa_pkg::STATUS_OK;
        if (mode == ffa_pkg::MODE_FREE) begin
            // unaligned addresses and those below the first header are dropped
            if (addr[2:0] == 3'b000 && addr >= ffa_pkg::HDR_BYTES &&
                (addr - ffa_pkg::HDR_BYTES) / 8 < STORE_WORDS) begin
                cur           = (addr - ffa_pkg::HDR_BYTES) / 8;
                blk_link[cur] = list_head;
                list_head     = cur;
            end
        end else begin
            want = (32'(req) + 32'd7) & ~32'd7;
            if (want < 8)
                want = 8;
            if (want > ffa_pkg::USABLE_BYTES) begin
                reply.status = ffa_pkg::STATUS_OOM;
            end else begin
                cur   = list_head;
                prev  = NO_LINK;
                steps = 0;
                // a looped list gives up after one lap of the whole store
                while (cur < STORE_WORDS && steps < STORE_WORDS && blk_size[cur] < want) begin
                    prev = cur;
                    cur  = blk_link[cur];
                    steps++;
                end
                if (cur >= STORE_WORDS || steps >= STORE_WORDS) begin
                    if (pages_used >= HEAP_PAGES) begin
                        reply.status = ffa_pkg::STATUS_OOM;
                    end else begin
                        cur           = pages_used * ffa_pkg::PAGE_WORDS;
                        blk_size[cur] = ffa_pkg::SIZE_W'(ffa_pkg::USABLE_BYTES);
                        blk_link[cur] = list_head;
                        list_head     = cur;
                        pages_used++;
                        prev          = NO_LINK;
                    end
                end
                if (reply.status == ffa_pkg::STATUS_OK) begin
                    if (prev == NO_LINK)
                        list_head = blk_link[cur];
                    else
                        blk_link[prev] = blk_link[cur];
                    spare         = blk_size[cur] - want;
                    blk_size[cur] = ffa_pkg::SIZE_W'(want);
                    blk_link[cur] = NO_LINK;
                    obj           = cur * 8 + ffa_pkg::HDR_BYTES;
                    // a tail of one header or less is simply lost
                    if (spare > ffa_pkg::HDR_BYTES) begin
                        split = (obj + want) / 8;
                        if (split < STORE_WORDS) begin
                            blk_size[split] = ffa_pkg::SIZE_W'(spare - ffa_pkg::HDR_BYTES);
                            blk_link[split] = list_head;
                            list_head       = split;
                        end
                    end
                    reply.obj_addr = ffa_pkg::ADDR_W'(obj);
                end
            end
        end
        reply.pages = ffa_pkg::PAGES_W'(pages_used);
        return reply;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe is matched against the oldest
    // expectation. Sampled at the rising edge, before the block updates.
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : check_reply
        t_heap_reply want;
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                note_mismatch("result with nothing outstanding, object address", 0,
                              32'(o_object_address));
            end else begin
                want = pending_replies.pop_front();
                if (o_object_address !== want.obj_addr)
                    note_mismatch("object address", 32'(want.obj_addr),
                                  32'(o_object_address));
                if (o_status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_pages_in_use !== want.pages)
                    note_mismatch("pages in use", 32'(want.pages), 32'(o_pages_in_use));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side. Inputs change on the falling edge; a transfer happens
    // at a rising edge with start high and busy low. start stays high on
    // return so that a back-to-back request needs no toggle.
    // ------------------------------------------------------------------
    task automatic send_request(input logic mode, input logic [ffa_pkg::REQ_W-1:0] req,
                                input logic [ffa_pkg::ADDR_W-1:0] addr,
                                output t_heap_reply reply);
        int          k;
        int unsigned idx;
        @(negedge i_clk);
        start           = 1'b1;
        i_mode          = mode;
        i_request_bytes = req;
        i_block_address = addr;
        do
            @(posedge i_clk);
        while (busy);
        reply = predict_heap(mode, req, addr);
        pending_replies.push_back(reply);
        // keep the set of live objects in step with the heap
        if (mode == ffa_pkg::MODE_ALLOC && reply.status == ffa_pkg::STATUS_OK) begin
            idx = (reply.obj_addr - ffa_pkg::HDR_BYTES) / 8;
            if (!obj_live[idx]) begin
                obj_live[idx] = 1'b1;
                live_objects.push_back(reply.obj_addr);
            end
        end else if (mode == ffa_pkg::MODE_FREE && addr[2:0] == 3'b000 &&
                     addr >= ffa_pkg::HDR_BYTES) begin
            idx = (addr - ffa_pkg::HDR_BYTES) / 8;
            if (obj_live[idx]) begin
                obj_live[idx] = 1'b0;
                for (k = 0; k < live_objects.size(); k++) begin
                    if (live_objects[k] == addr) begin
                        live_objects.delete(k);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_results;
        @(negedge i_clk);
        start = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap(input bit burst);
        int r;
        r = int'($urandom_range(99));
        if (burst || r < 60)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    function automatic logic [ffa_pkg::ADDR_W-1:0] any_address();
        logic [ffa_pkg::ADDR_W-1:0] a;
        a = ffa_pkg::ADDR_W'($urandom);
        return a;
    endfunction

    function automatic logic [ffa_pkg::REQ_W-1:0] any_request();
        logic [ffa_pkg::REQ_W-1:0] q;
        q = ffa_pkg::REQ_W'($urandom);
        return q;
    endfunction

    // Small sizes dominate so that pages last; odd and oversized ones included.
    function automatic logic [ffa_pkg::REQ_W-1:0] pick_request_size();
        int r;
        r = int'($urandom_range(99));
        if (r < 50)
            return ffa_pkg::REQ_W'($urandom_range(0, 128));
        if (r < 80)
            return ffa_pkg::REQ_W'($urandom_range(129, 1024));
        if (r < 95)
            return ffa_pkg::REQ_W'($urandom_range(1025, ffa_pkg::USABLE_BYTES));
        return any_request();
    endfunction

    // Addresses the block must ignore: unaligned, or below the first header.
    function automatic logic [ffa_pkg::ADDR_W-1:0] malformed_address();
        logic [ffa_pkg::ADDR_W-1:0] a;
        if ($urandom_range(3) == 0) begin
            a = ffa_pkg::ADDR_W'($urandom_range(1) * 8);
        end else begin
            a      = ffa_pkg::ADDR_W'($urandom);
            a[2:0] = 3'($urandom_range(1, 7));
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Size rounding: zero and odd sizes, the exact page fit, oversized requests.
    task automatic test_request_rounding;
        t_heap_reply rep;
        send_request(ffa_pkg::MODE_ALLOC, 12'd0, any_address(), rep);
        first_obj = rep.obj_addr;
        send_request(ffa_pkg::MODE_ALLOC, 12'd1, any_address(), rep);
        send_request(ffa_pkg::MODE_ALLOC, 12'd7, any_address(), rep);
        send_request(ffa_pkg::MODE_ALLOC, 12'd9, any_address(), rep);
        send_request(ffa_pkg::MODE_ALLOC, ffa_pkg::REQ_W'(ffa_pkg::USABLE_BYTES),
                     any_address(), rep);
        page_obj = rep.obj_addr;
        send_request(ffa_pkg::MODE_ALLOC, ffa_pkg::REQ_W'(ffa_pkg::USABLE_BYTES + 1),
                     any_address(), rep);
        send_request(ffa_pkg::MODE_ALLOC, 12'hFFF, any_address(), rep);
    endtask

    // Tails of 8 and 16 bytes are lost; 24 bytes leave an 8-byte block,
    // which the next small request takes from the list front.
    task automatic test_remainder_split;
        t_heap_reply rep;
        send_request(ffa_pkg::MODE_ALLOC, ffa_pkg::REQ_W'(ffa_pkg::USABLE_BYTES - 8),
                     any_address(), rep);
        send_request(ffa_pkg::MODE_ALLOC, ffa_pkg::REQ_W'(ffa_pkg::USABLE_BYTES - 16),
                     any_address(), rep);
        send_request(ffa_pkg::MODE_ALLOC, ffa_pkg::REQ_W'(ffa_pkg::USABLE_BYTES - 24),
                     any_address(), rep);
        send_request(ffa_pkg::MODE_ALLOC, 12'd8, any_address(), rep);
    endtask

    // Valid frees are reused first; malformed addresses change nothing.
    task automatic test_free_handling;
        t_heap_reply rep;
        send_request(ffa_pkg::MODE_FREE, any_request(), first_obj, rep);
        send_request(ffa_pkg::MODE_FREE, any_request(), 18'h00003, rep);
        send_request(ffa_pkg::MODE_FREE, any_request(), 18'h3FFFF, rep);
        send_request(ffa_pkg::MODE_FREE, any_request(), 18'h00000, rep);
        send_request(ffa_pkg::MODE_FREE, any_request(), 18'h00008, rep);
        send_request(ffa_pkg::MODE_ALLOC, 12'd8, any_address(), rep);
        send_request(ffa_pkg::MODE_FREE, any_request(), page_obj, rep);
        send_request(ffa_pkg::MODE_ALLOC, 12'd4000, any_address(), rep);
    endtask

    // A block freed twice links to itself; a request too big for it walks
    // the loop until the walk limit, then takes a new page. Two exact-size requests
    // afterwards leave the list empty again.
    task automatic test_double_free;
        t_heap_reply                rep;
        logic [ffa_pkg::ADDR_W-1:0] twice;
        send_request(ffa_pkg::MODE_ALLOC, 12'd64, any_address(), rep);
        twice = rep.obj_addr;
        send_request(ffa_pkg::MODE_FREE, any_request(), twice, rep);
        send_request(ffa_pkg::MODE_FREE, any_request(), twice, rep);
        send_request(ffa_pkg::MODE_ALLOC, ffa_pkg::REQ_W'(ffa_pkg::USABLE_BYTES),
                     any_address(), rep);
        send_request(ffa_pkg::MODE_ALLOC, 12'd64, any_address(), rep);
        send_request(ffa_pkg::MODE_ALLOC, 12'd64, any_address(), rep);
    endtask

    // Mixed allocations and frees of live objects, with malformed frees as
    // noise; the sender drains everything now and then.
    task automatic test_random_traffic(input int count);
        t_heap_reply rep;
        int          n, r, pick;
        bit          burst;
        burst = 1'b0;
        for (n = 0; n < count; n++) begin
            if (n % 64 == 0)
                burst = ($urandom_range(3) == 0);
            if (n > 0 && n % 250 == 0)
                wait_for_results();
            r = int'($urandom_range(99));
            if (r < 50 || (r < 88 && live_objects.size() == 0)) begin
                send_request(ffa_pkg::MODE_ALLOC, pick_request_size(), any_address(), rep);
            end else if (r < 88) begin
                pick = int'($urandom_range(live_objects.size() - 1));
                send_request(ffa_pkg::MODE_FREE, any_request(), live_objects[pick], rep);
            end else begin
                send_request(ffa_pkg::MODE_FREE, any_request(), malformed_address(), rep);
            end
            hold_off(pick_gap(burst));
        end
    endtask

    // Whole-page requests until the pages run out, then traffic at the limit.
    task automatic test_heap_exhaustion;
        t_heap_reply rep;
        int          n;
        bit          full;
        full = 1'b0;
        for (n = 0; n < 200 && !full; n++) begin
            send_request(ffa_pkg::MODE_ALLOC, ffa_pkg::REQ_W'(ffa_pkg::USABLE_BYTES),
                         any_address(), rep);
            full = (rep.status == ffa_pkg::STATUS_OOM);
            hold_off(pick_gap(1'b0));
        end
        send_request(ffa_pkg::MODE_ALLOC, 12'd8, any_address(), rep);
        if (live_objects.size() != 0)
            send_request(ffa_pkg::MODE_FREE, any_request(), live_objects[0], rep);
        send_request(ffa_pkg::MODE_ALLOC, ffa_pkg::REQ_W'(ffa_pkg::USABLE_BYTES),
                     any_address(), rep);
        send_request(ffa_pkg::MODE_ALLOC, 12'hFFF, any_address(), rep);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_request_rounding();
        test_remainder_split();
        test_free_handling();
        test_double_free();
        wait_for_results();
        test_random_traffic(1200);
        test_heap_exhaustion();

        // let any stray strobe show up before the verdict
        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: a time limit beyond even a full-store walk per request.
    initial begin
        #1_000_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
